// ===== rtl/core/sudiv_pkg.sv =====
// Shared types and constants for the pipelined signed/unsigned integer divider.
// Used by every module under rtl/core; depends on nothing.
package sudiv_pkg;

    localparam int DATA_W      = 64;  // width of the operand and result ports
    localparam int ACT_W       = 2;
    localparam int WIDTH_DFLT  = 64;  // default arithmetic width

    localparam logic [ACT_W-1:0] ACT_SQUO = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SREM = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UQUO = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UREM = 2'd3;

    // Control that rides along with each request through the pipeline.
    typedef struct packed {
        logic rem_op;  // deliver the remainder instead of the quotient
        logic neg;     // negate the selected magnitude at the end
        logic dbz;     // divisor was zero
    } ctrl_t;

endpackage

// ===== rtl/core/sudiv_prep.sv =====
// Input stage of the divider: decodes the action and takes operand magnitudes.
// Depends on sudiv_pkg.
module sudiv_prep #(
    parameter int WIDTH = sudiv_pkg::WIDTH_DFLT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           valid_in,
    input  logic [sudiv_pkg::ACT_W-1:0]    action,
    input  logic [sudiv_pkg::DATA_W-1:0]   dividend,
    input  logic [sudiv_pkg::DATA_W-1:0]   divisor,
    output logic                           valid_out,
    output sudiv_pkg::ctrl_t               ctrl_out,
    output logic [WIDTH-1:0]               num_out,
    output logic [WIDTH-1:0]               dvs_out
);

    logic              valid_reg;
    sudiv_pkg::ctrl_t  ctrl_reg, ctrl_next;
    logic [WIDTH-1:0]  num_reg, num_next;
    logic [WIDTH-1:0]  dvs_reg, dvs_next;
    logic [WIDTH-1:0]  n_raw, d_raw;
    logic              is_signed, n_neg, d_neg;

    always_comb begin
        n_raw     = dividend[WIDTH-1:0];
        d_raw     = divisor[WIDTH-1:0];
        is_signed = (action == sudiv_pkg::ACT_SQUO) || (action == sudiv_pkg::ACT_SREM);
        n_neg     = is_signed & n_raw[WIDTH-1];
        d_neg     = is_signed & d_raw[WIDTH-1];
        // The most negative value negates to itself, which read unsigned is 2^(WIDTH-1).
        num_next  = n_neg ? (~n_raw + 1'b1) : n_raw;
        dvs_next  = d_neg ? (~d_raw + 1'b1) : d_raw;
        ctrl_next.rem_op = (action == sudiv_pkg::ACT_SREM) || (action == sudiv_pkg::ACT_UREM);
        ctrl_next.neg    = ctrl_next.rem_op ? n_neg : (n_neg ^ d_neg);
        ctrl_next.dbz    = (d_raw == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg <= ctrl_next;
            num_reg  <= num_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctrl_out  = ctrl_reg;
    assign num_out   = num_reg;
    assign dvs_out   = dvs_reg;

endmodule

// ===== rtl/core/sudiv_stage.sv =====
// One restoring-division step: develops one quotient bit per register stage.
// Depends on sudiv_pkg.
module sudiv_stage #(
    parameter int WIDTH = sudiv_pkg::WIDTH_DFLT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  sudiv_pkg::ctrl_t  ctrl_in,
    input  logic [WIDTH-1:0]  rem_in,
    input  logic [WIDTH-1:0]  quo_in,
    input  logic [WIDTH-1:0]  dvs_in,
    output logic              valid_out,
    output sudiv_pkg::ctrl_t  ctrl_out,
    output logic [WIDTH-1:0]  rem_out,
    output logic [WIDTH-1:0]  quo_out,
    output logic [WIDTH-1:0]  dvs_out
);

    logic              valid_reg;
    sudiv_pkg::ctrl_t  ctrl_reg;
    logic [WIDTH-1:0]  rem_reg, rem_next;
    logic [WIDTH-1:0]  quo_reg, quo_next;
    logic [WIDTH-1:0]  dvs_reg;
    logic [WIDTH:0]    trial, diff;

    // The quotient register starts out holding the dividend; its top bit is
    // shifted into the partial remainder while the new quotient bit enters below.
    always_comb begin
        trial = {rem_in, quo_in[WIDTH-1]};
        diff  = trial - {1'b0, dvs_in};
        if (!diff[WIDTH]) begin
            rem_next = diff[WIDTH-1:0];
            quo_next = {quo_in[WIDTH-2:0], 1'b1};
        end else begin
            rem_next = trial[WIDTH-1:0];
            quo_next = {quo_in[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg <= ctrl_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_in;
        end
    end

    assign valid_out = valid_reg;
    assign ctrl_out  = ctrl_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign dvs_out   = dvs_reg;

endmodule

// ===== rtl/core/sudiv_post.sv =====
// Output stage of the divider: selects, sign-corrects and registers the result, or zero on a zero divisor.
// Depends on sudiv_pkg.
module sudiv_post #(
    parameter int WIDTH = sudiv_pkg::WIDTH_DFLT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          valid_in,
    input  sudiv_pkg::ctrl_t              ctrl_in,
    input  logic [WIDTH-1:0]              rem_in,
    input  logic [WIDTH-1:0]              quo_in,
    output logic                          valid_out,
    output logic [sudiv_pkg::DATA_W-1:0]  result,
    output logic                          div_by_zero
);

    logic                          valid_reg;
    logic [sudiv_pkg::DATA_W-1:0]  result_reg, result_next;
    logic                          dbz_reg;
    logic [WIDTH-1:0]              mag, signed_val;

    always_comb begin
        mag        = ctrl_in.rem_op ? rem_in : quo_in;
        signed_val = ctrl_in.neg ? (~mag + 1'b1) : mag;
        result_next = '0;
        if (!ctrl_in.dbz) begin
            result_next[WIDTH-1:0] = signed_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
            dbz_reg    <= ctrl_in.dbz;
        end
    end

    assign valid_out   = valid_reg;
    assign result      = result_reg;
    assign div_by_zero = dbz_reg;

endmodule

// ===== rtl/core/signed_unsigned_int_divider.sv =====
// Top level of the pipelined signed/unsigned integer divider.
// Depends on sudiv_pkg, sudiv_prep, sudiv_stage and sudiv_post.
//
// Fully pipelined divider: it accepts one request per clock while the output is
// not stalled and returns one result per request, in order. The stage that takes
// operand magnitudes registers the request at acceptance, WIDTH restoring-division
// stages each develop one quotient bit with a single WIDTH+1 bit subtract, and one
// stage applies the sign and registers the result. The whole pipeline advances
// together; it holds only while a result waits at the output and m_ready is low.
// Signed actions truncate toward zero and give the remainder the sign of the
// dividend; a zero divisor returns zero with m_div_by_zero set. Only the low
// WIDTH bits of the operands are used and the upper result bits are zero.
module signed_unsigned_int_divider #(
    parameter int WIDTH = sudiv_pkg::WIDTH_DFLT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sudiv_pkg::ACT_W-1:0]    s_action,
    input  logic [sudiv_pkg::DATA_W-1:0]   s_dividend,
    input  logic [sudiv_pkg::DATA_W-1:0]   s_divisor,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sudiv_pkg::DATA_W-1:0]   m_result,
    output logic                           m_div_by_zero
);

    logic              en;
    logic              valid_chain [WIDTH+1];
    sudiv_pkg::ctrl_t  ctrl_chain  [WIDTH+1];
    logic [WIDTH-1:0]  rem_chain   [WIDTH+1];
    logic [WIDTH-1:0]  quo_chain   [WIDTH+1];
    logic [WIDTH-1:0]  dvs_chain   [WIDTH+1];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    sudiv_prep #(.WIDTH(WIDTH)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_valid),
        .action    (s_action),
        .dividend  (s_dividend),
        .divisor   (s_divisor),
        .valid_out (valid_chain[0]),
        .ctrl_out  (ctrl_chain[0]),
        .num_out   (quo_chain[0]),
        .dvs_out   (dvs_chain[0])
    );

    assign rem_chain[0] = '0;

    for (genvar i = 0; i < WIDTH; i++) begin : g_step
        sudiv_stage #(.WIDTH(WIDTH)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (valid_chain[i]),
            .ctrl_in   (ctrl_chain[i]),
            .rem_in    (rem_chain[i]),
            .quo_in    (quo_chain[i]),
            .dvs_in    (dvs_chain[i]),
            .valid_out (valid_chain[i+1]),
            .ctrl_out  (ctrl_chain[i+1]),
            .rem_out   (rem_chain[i+1]),
            .quo_out   (quo_chain[i+1]),
            .dvs_out   (dvs_chain[i+1])
        );
    end

    sudiv_post #(.WIDTH(WIDTH)) u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .valid_in    (valid_chain[WIDTH]),
        .ctrl_in     (ctrl_chain[WIDTH]),
        .rem_in      (rem_chain[WIDTH]),
        .quo_in      (quo_chain[WIDTH]),
        .valid_out   (m_valid),
        .result      (m_result),
        .div_by_zero (m_div_by_zero)
    );

endmodule

// ===== rtl/core/sudiv_checker.sv =====
// Port-level checks for the divider, attached to the top level by bind.
// Depends on sudiv_pkg and signed_unsigned_int_divider.
module sudiv_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_ready,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [sudiv_pkg::DATA_W-1:0]   m_result,
    input  logic                           m_div_by_zero
);

    // A result waiting at the output must hold until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result) && $stable(m_div_by_zero))
        else $error("result changed or dropped while stalled");

    // A zero divisor always yields a zero result word.
    a_dbz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_by_zero |-> m_result == '0)
        else $error("divide by zero returned a nonzero result");

    // The pipeline takes requests exactly when its output slot can drain.
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind signed_unsigned_int_divider sudiv_checker u_sudiv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result      (m_result),
    .m_div_by_zero (m_div_by_zero)
);
